FILE: rtl/teq_pkg.sv
// types and constants shared by the time-ordered event queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

    localparam int TIME_W  = 32;
    localparam int TYPE_W  = 8;
    localparam int ID_W    = 16;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] time_stamp;
        logic [TYPE_W-1:0] action_type;
        logic [ID_W-1:0]   action_id;
    } teq_entry_t;

    // one-cycle operation broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_pop;
        logic do_clear;
    } teq_op_t;

endpackage

`default_nettype wire

FILE: rtl/teq_cell.sv
// one slot of the sorted shift-register queue
// depends on teq_pkg
`timescale 1ns / 1ps
`default_nettype none

module teq_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire teq_pkg::teq_op_t    op,
    input  wire teq_pkg::teq_entry_t new_entry,
    input  wire logic                left_le,
    input  wire logic                left_valid,
    input  wire teq_pkg::teq_entry_t left_entry,
    input  wire logic                right_valid,
    input  wire teq_pkg::teq_entry_t right_entry,
    output logic                     le,
    output logic                     valid,
    output teq_pkg::teq_entry_t      entry
);
    import teq_pkg::*;

    logic       valid_reg, valid_next;
    teq_entry_t entry_reg, entry_next;

    // held entry sorts before or ties with the new one
    assign le    = valid_reg && (entry_reg.time_stamp <= new_entry.time_stamp);
    assign valid = valid_reg;
    assign entry = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        priority if (op.do_clear) begin
            valid_next = 1'b0;
        end else if (op.do_pop) begin
            valid_next = right_valid;
            entry_next = right_entry;
        end else if (op.do_insert) begin
            valid_next = valid_reg || left_valid;
            if (!le) begin
                // boundary lands here, otherwise shift one place up
                entry_next = left_le ? new_entry : left_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: rtl/time_ordered_event_queue_unit.sv
// top level of the time-ordered event queue: chain of teq_cell slots
// depends on teq_pkg and teq_cell
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Each input item on s_axis carries a command: insert (time stamp, action
// type, action id), pop the earliest entry, or clear. Every item gives
// exactly one result item on m_axis: status, the popped entry (zero when
// nothing is popped) and the fill count after the item.
// Entries stay sorted by ascending time; equal times leave in arrival order.
// All slots compare against the new time in parallel and shift by one place
// in the same cycle; the result is registered and shows in the cycle after
// acceptance, and one item per cycle is sustained while m_axis_tready is high.
// An insert into a full queue returns status full; a pop on an empty queue
// returns status empty; the queue is left unchanged in both cases.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result. While m_axis_tready is low a result waits in the output register
// and s_axis_tready goes low; it rises again in the cycle the result is taken.
module time_ordered_event_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // command[1:0], time_stamp[33:2], action_type[41:34], action_id[57:42], zero fill
    input  wire logic [teq_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status[1:0], out_time[33:2], out_type[41:34], out_id[57:42],
    // fill_count[62:58], zero fill
    output logic [teq_pkg::M_DATA_W-1:0]       m_axis_tdata
);
    import teq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CMD_W-1:0] cmd;
    teq_entry_t       new_entry;
    logic             accept;
    logic             full, empty;
    teq_op_t          op;

    logic [QUEUE_DEPTH-1:0] cell_le, cell_valid;
    teq_entry_t             cell_entry [QUEUE_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [FILL_W-1:0] fill_count;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0]   status;
    teq_entry_t          out_entry;

    assign cmd                   = s_axis_tdata[1:0];
    assign new_entry.time_stamp  = s_axis_tdata[33:2];
    assign new_entry.action_type = s_axis_tdata[41:34];
    assign new_entry.action_id   = s_axis_tdata[57:42];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = cell_valid[QUEUE_DEPTH-1];
    assign empty         = !cell_valid[0];

    assign op.do_insert = accept && (cmd == CMD_INSERT) && !full;
    assign op.do_pop    = accept && (cmd == CMD_POP) && !empty;
    assign op.do_clear  = accept && (cmd == CMD_CLEAR);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic       l_le, l_valid, r_valid;
            teq_entry_t l_entry, r_entry;
            if (gi == 0) begin : g_head
                // virtual neighbour before the head always sorts first
                assign l_le    = 1'b1;
                assign l_valid = 1'b1;
                assign l_entry = new_entry;
            end else begin : g_body
                assign l_le    = cell_le[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_entry = cell_entry[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign r_valid = 1'b0;
                assign r_entry = cell_entry[gi];
            end else begin : g_inner
                assign r_valid = cell_valid[gi+1];
                assign r_entry = cell_entry[gi+1];
            end
            teq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .op          (op),
                .new_entry   (new_entry),
                .left_le     (l_le),
                .left_valid  (l_valid),
                .left_entry  (l_entry),
                .right_valid (r_valid),
                .right_entry (r_entry),
                .le          (cell_le[gi]),
                .valid       (cell_valid[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        status     = ST_OK;
        out_entry  = '0;
        unique case (cmd)
            CMD_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    out_entry  = cell_entry[0];
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign fill_count  = FILL_W'(count_next);
    assign m_data_next = {1'b0, fill_count, out_entry.action_id,
                          out_entry.action_type, out_entry.time_stamp, status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire
